@@ rtl/core/rs_hash_bucket_index_defines.svh @@
// rs_hash_bucket_index_defines.svh: assertion macros for the hash bucket block checkers
// depends on: nothing; the user module must provide clk_i and rst_ni
`ifndef RS_HASH_BUCKET_INDEX_DEFINES_SVH
`define RS_HASH_BUCKET_INDEX_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RSHBI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rshbi same-cycle check failed");

// next-cycle implication, checked outside reset
`define RSHBI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rshbi next-cycle check failed");

`endif

@@ rtl/core/rshbi_pkg.sv @@
// rshbi_pkg: constants and shared types of the hash bucket block
// depends on: nothing
package rshbi_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  // rs hash constants
  localparam word_t MultInit    = 32'd63689;
  localparam word_t MultStep    = 32'd378551;
  localparam word_t BucketReset = 32'd65536;

  // hash queue between the front and the divider
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // restoring divider, one quotient bit per cycle
  localparam int unsigned DivSteps = WordW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ rtl/core/rshbi_front.sv @@
// rshbi_front: accepts coordinates and keeps the running rs hash and multiplier
// depends on: rshbi_pkg
module rshbi_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  rshbi_pkg::word_t coordinate_i,
  input  logic            last_coordinate_i,
  output logic            hash_push_o,
  output rshbi_pkg::word_t hash_o
);

  rshbi_pkg::word_t hash_q, hash_d;
  rshbi_pkg::word_t mult_q, mult_d;
  rshbi_pkg::word_t hash_next;

  // both products keep only the low word
  assign hash_next = hash_q * mult_q + coordinate_i;

  always_comb begin
    hash_d = hash_q;
    mult_d = mult_q;
    if (accept_i) begin
      if (last_coordinate_i) begin
        hash_d = '0;
        mult_d = rshbi_pkg::MultInit;
      end else begin
        hash_d = hash_next;
        mult_d = mult_q * rshbi_pkg::MultStep;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      mult_q <= rshbi_pkg::MultInit;
    end else begin
      hash_q <= hash_d;
      mult_q <= mult_d;
    end
  end

  assign hash_push_o = accept_i & last_coordinate_i;
  assign hash_o      = hash_next;

endmodule

@@ rtl/core/rshbi_fifo.sv @@
// rshbi_fifo: short queue of finished hashes between the front and the divider
// depends on: rshbi_pkg
module rshbi_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rshbi_pkg::word_t     data_i,
  input  logic                 pop_i,
  output rshbi_pkg::word_t     data_o,
  output rshbi_pkg::q_status_t status_o
);

  rshbi_pkg::word_t                mem_q [rshbi_pkg::QDepth];
  logic [rshbi_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [rshbi_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [rshbi_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign status_o.full  = (cnt_q == rshbi_pkg::QCntW'(rshbi_pkg::QDepth));
  assign status_o.empty = (cnt_q == '0);

  assign do_push = push_i & ~status_o.full;
  assign do_pop  = pop_i & ~status_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == rshbi_pkg::QPtrW'(rshbi_pkg::QDepth - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == rshbi_pkg::QPtrW'(rshbi_pkg::QDepth - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o = mem_q[rd_ptr_q];

endmodule

@@ rtl/core/rshbi_divider.sv @@
// rshbi_divider: reduces queued hashes modulo the bucket count (a zero count passes the hash) and holds the result word
// depends on: rshbi_pkg
module rshbi_divider (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rshbi_pkg::q_status_t q_status_i,
  input  rshbi_pkg::word_t     q_data_i,
  output logic                 q_pop_o,
  input  rshbi_pkg::word_t     modulus_i,
  input  logic                 out_pop_i,
  output logic                 out_valid_o,
  output rshbi_pkg::word_t     out_data_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic [rshbi_pkg::DivCntW-1:0] cnt_q, cnt_d;
  rshbi_pkg::word_t              rem_q, rem_d;
  rshbi_pkg::word_t              dvd_q, dvd_d;
  rshbi_pkg::word_t              div_q, div_d;
  logic                          out_valid_q, out_valid_d;
  rshbi_pkg::word_t              out_data_q, out_data_d;
  logic [rshbi_pkg::WordW:0]     trial, diff;
  logic                          out_free;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, dvd_q[rshbi_pkg::WordW-1]};
  assign diff  = trial - {1'b0, div_q};

  assign out_free = ~out_valid_q | out_pop_i;
  assign q_pop_o  = (state_q == StIdle) & ~q_status_i.empty;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    div_d       = div_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (!q_status_i.empty) begin
          div_d = modulus_i;
          cnt_d = '0;
          if (modulus_i == '0) begin
            // zero bucket count passes the full hash
            rem_d   = q_data_i;
            state_d = StDone;
          end else begin
            rem_d   = '0;
            dvd_d   = q_data_i;
            state_d = StRun;
          end
        end
      end
      StRun: begin
        rem_d = diff[rshbi_pkg::WordW] ? trial[rshbi_pkg::WordW-1:0]
                                       : diff[rshbi_pkg::WordW-1:0];
        dvd_d = {dvd_q[rshbi_pkg::WordW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == rshbi_pkg::DivCntW'(rshbi_pkg::DivSteps - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = rem_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    div_q      <= div_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/core/rs_hash_bucket_index.sv @@
// rs_hash_bucket_index: one coordinate per cycle while the hash queue is not full; front keeps
// the rs hash with one multiply-add; a point's hash goes through the hash queue to the divider
// and from there into the output word register; the divider takes one restoring step per hash
// bit and takes no new hash until the last is out; a two-entry hash queue decouples the front
// async active-low reset: hash 0, multiplier 63689, bucket count 65536, queue and output empty
// depends on: rshbi_pkg, rshbi_front, rshbi_fifo, rshbi_divider
module rs_hash_bucket_index (
  input  logic             clk_i,
  input  logic             rst_ni,
  // coordinate channel
  input  logic             push,
  output logic             full,
  input  rshbi_pkg::word_t coordinate_i,
  input  logic             last_coordinate_i,
  // result channel
  output logic             empty,
  input  logic             pop,
  output rshbi_pkg::word_t bucket_index_o,
  // bucket count register write
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  rshbi_pkg::word_t cfg_data_i
);

  rshbi_pkg::word_t     modulus_q;
  rshbi_pkg::q_status_t q_status;
  rshbi_pkg::word_t     front_hash, q_data;
  logic                 front_push, q_pop, in_accept, out_valid;

  // writes are taken at any time, unchecked; the user must keep the block idle then
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= rshbi_pkg::BucketReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      modulus_q <= cfg_data_i;
    end
  end

  // front stalls only while the hash queue is full
  assign full      = q_status.full;
  assign in_accept = push & ~q_status.full;

  rshbi_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (in_accept),
    .coordinate_i      (coordinate_i),
    .last_coordinate_i (last_coordinate_i),
    .hash_push_o       (front_push),
    .hash_o            (front_hash)
  );

  // finished hashes wait here for the divider
  rshbi_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (front_push),
    .data_i   (front_hash),
    .pop_i    (q_pop),
    .data_o   (q_data),
    .status_o (q_status)
  );

  // back part: modulo and the output word register
  rshbi_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .modulus_i   (modulus_q),
    .out_pop_i   (pop),
    .out_valid_o (out_valid),
    .out_data_o  (bucket_index_o)
  );

  assign empty = ~out_valid;

endmodule

@@ rtl/core/rshbi_checker.sv @@
// rshbi_checker: port-level checks of the hash bucket block, bound to the top level
// depends on: rs_hash_bucket_index_defines.svh, rs_hash_bucket_index
`include "rs_hash_bucket_index_defines.svh"

module rshbi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic [31:0] coordinate_i,
  input logic        last_coordinate_i,
  input logic        empty,
  input logic        pop,
  input logic [31:0] bucket_index_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [31:0] cfg_data_i
);

  // points accepted whose word has not yet been taken
  logic [2:0] pend_q, pend_d;
  logic       in_last, out_take;

  assign in_last  = push & ~full & last_coordinate_i;
  assign out_take = pop & ~empty;

  always_comb begin
    pend_d = pend_q;
    unique case ({in_last, out_take})
      2'b10:   pend_d = pend_q + 1'b1;
      2'b01:   pend_d = pend_q - 1'b1;
      default: pend_d = pend_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `RSHBI_ASSERT_NOW(a_no_spurious_word, !empty, pend_q != 3'd0)
  `RSHBI_ASSERT_NOW(a_full_needs_backlog, full, pend_q >= 3'd2)
  `RSHBI_ASSERT_NEXT(a_word_holds, !empty && !pop, !empty && $stable(bucket_index_o))

endmodule

bind rs_hash_bucket_index rshbi_checker u_rshbi_checker (.*);
